[rtl/dtf_pkg.sv]
// Shared types, constants and the digit table for the decimal text to float32 parser.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package dtf_pkg;

  localparam int CHAR_W       = 8;
  localparam int VAL_W        = 32;
  localparam int EXPONENT_CAP = 255;
  localparam int EXP_W        = $clog2(EXPONENT_CAP + 1);

  localparam logic [31:0] F32_ZERO  = 32'h0000_0000;
  localparam logic [31:0] F32_TENTH = 32'h3DCC_CCCD;
  localparam logic [31:0] F32_INF   = 32'h7F80_0000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  localparam logic [3:0] K_TEN = 4'd10;

  typedef enum logic [2:0] {
    SEC_LEAD,
    SEC_INT,
    SEC_FRAC,
    SEC_EXPSIGN,
    SEC_EXPDIG,
    SEC_DONE
  } section_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_DIV
  } fpu_op_t;

  typedef struct packed {
    logic       start;
    fpu_op_t    op;
    logic [3:0] k;
  } fpu_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } fpu_sts_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIVN,
    F_DIV,
    F_NORM,
    F_ROUND
  } fpu_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_INT_MUL,
    T_INT_ADD,
    T_FRAC_MUL,
    T_FRAC_ADD,
    T_FRAC_DIV,
    T_EXP,
    T_EMIT
  } seq_state_t;

  function automatic logic [31:0] digit_f32(input logic [3:0] d);
    logic [31:0] r;
    unique case (d)
      4'd1:    r = 32'h3F80_0000;
      4'd2:    r = 32'h4000_0000;
      4'd3:    r = 32'h4040_0000;
      4'd4:    r = 32'h4080_0000;
      4'd5:    r = 32'h40A0_0000;
      4'd6:    r = 32'h40C0_0000;
      4'd7:    r = 32'h40E0_0000;
      4'd8:    r = 32'h4100_0000;
      4'd9:    r = 32'h4110_0000;
      default: r = F32_ZERO;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/dtf_chan_if.sv]
// Valid/ready channel interfaces for text bytes and float32 results.
// Depends on dtf_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface dtf_char_if;
  logic                        valid;
  logic                        ready;
  logic [dtf_pkg::CHAR_W-1:0]  char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface dtf_bits_if;
  logic                       valid;
  logic                       ready;
  logic [dtf_pkg::VAL_W-1:0]  value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

`default_nettype wire

[rtl/dtf_fpu.sv]
// Shared multicycle float32 unit for nonnegative operands: multiply by a small
// integer, add, and divide by ten (three 12-bit reciprocal-multiply steps),
// with round to nearest even. Depends on dtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtf_fpu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dtf_pkg::fpu_req_t req,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output dtf_pkg::fpu_sts_t      sts,
  output logic [31:0]            res
);
  import dtf_pkg::*;

  localparam logic [5:0]  DIV_STEPS = 6'd3;
  localparam logic [16:0] RECIP_TEN = 17'd52429;

  fpu_state_t         st_r, st_nxt;
  logic [32:0]        w_r, w_nxt;
  logic signed [10:0] ex_r, ex_nxt;
  logic               stk_r, stk_nxt;
  logic [35:0]        n_r, n_nxt;
  logic [35:0]        q_r, q_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [31:0]        res_r, res_nxt;
  logic               done_r, done_nxt;

  logic [7:0]         fld_a, fld_b;
  logic [23:0]        ma, mb, mbig, msm;
  logic signed [10:0] ea, eb, ebig, esm, diff, sh;
  logic [5:0]         dc, shc;
  logic [63:0]        sh64;
  logic [27:0]        prod;
  logic [15:0]        dvd;
  logic [31:0]        qprod;
  logic [11:0]        qdig;
  logic [15:0]        qback;
  logic               up;
  logic [24:0]        m25;
  logic signed [10:0] fld;

  always_comb begin
    fld_a = a[30:23];
    fld_b = b[30:23];
    ma    = (fld_a == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    mb    = (fld_b == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
    ea    = (fld_a == 8'd0) ? 11'sd1 : $signed({3'b000, fld_a});
    eb    = (fld_b == 8'd0) ? 11'sd1 : $signed({3'b000, fld_b});
    if (ea >= eb) begin
      mbig = ma; ebig = ea; msm = mb; esm = eb;
    end else begin
      mbig = mb; ebig = eb; msm = ma; esm = ea;
    end
    diff  = ebig - esm;
    dc    = (diff > 11'sd32) ? 6'd32 : diff[5:0];
    prod  = 28'(ma) * 28'(req.k);
    dvd   = {rem_r, n_r[35:24]};
    qprod = 32'(dvd) * 32'(RECIP_TEN);
    qdig  = qprod[30:19];
    qback = {3'b000, qdig, 1'b0} + {1'b0, qdig, 3'b000};
    sh    = 11'sd1 - ex_r;
    shc   = (sh > 11'sd32) ? 6'd32 : sh[5:0];
    up    = w_r[7] & ((|w_r[6:0]) | stk_r | w_r[8]);
    m25   = {1'b0, w_r[31:8]} + {24'd0, up};
    fld   = w_r[31] ? (ex_r + $signed({10'd0, m25[24]})) : $signed({10'd0, m25[23]});
    sh64  = 64'd0;

    st_nxt   = st_r;
    w_nxt    = w_r;
    ex_nxt   = ex_r;
    stk_nxt  = stk_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;

    unique case (st_r)
      F_IDLE: begin
        if (req.start) begin
          if (fld_a == 8'hFF || (req.op == OP_ADD && fld_b == 8'hFF)) begin
            res_nxt  = F32_INF;
            done_nxt = 1'b1;
          end else begin
            unique case (req.op)
              OP_MUL: begin
                w_nxt   = {1'b0, prod, 4'b0000};
                ex_nxt  = ea + 11'sd4;
                stk_nxt = 1'b0;
                st_nxt  = F_NORM;
              end
              OP_ADD: begin
                sh64    = {msm, 8'd0, 32'd0} >> dc;
                w_nxt   = {1'b0, mbig, 8'd0} + {1'b0, sh64[63:32]};
                ex_nxt  = ebig;
                stk_nxt = |sh64[31:0];
                st_nxt  = F_NORM;
              end
              OP_DIV: begin
                w_nxt   = {1'b0, ma, 8'd0};
                ex_nxt  = ea;
                stk_nxt = 1'b0;
                st_nxt  = F_DIVN;
              end
              default: begin
                res_nxt  = F32_ZERO;
                done_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      F_DIVN: begin
        if (w_r[31] || w_r[31:0] == 32'd0) begin
          n_nxt   = {w_r[31:0], 4'b0000};
          q_nxt   = 36'd0;
          rem_nxt = 4'd0;
          cnt_nxt = DIV_STEPS;
          st_nxt  = F_DIV;
        end else begin
          w_nxt  = {w_r[31:0], 1'b0};
          ex_nxt = ex_r - 11'sd1;
        end
      end
      F_DIV: begin
        rem_nxt = 4'(dvd - qback);
        q_nxt   = {q_r[23:0], qdig};
        n_nxt   = {n_r[23:0], 12'd0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          w_nxt   = q_nxt[32:0];
          stk_nxt = (rem_nxt != 4'd0);
          ex_nxt  = ex_r - 11'sd4;
          st_nxt  = F_NORM;
        end
      end
      F_NORM: begin
        priority if (w_r[32]) begin
          w_nxt   = {1'b0, w_r[32:1]};
          stk_nxt = stk_r | w_r[0];
          ex_nxt  = ex_r + 11'sd1;
        end else if (!w_r[31] && ex_r > 11'sd1) begin
          w_nxt  = {w_r[31:0], 1'b0};
          ex_nxt = ex_r - 11'sd1;
        end else if (ex_r < 11'sd1) begin
          sh64    = {w_r[31:0], 32'd0} >> shc;
          w_nxt   = {1'b0, sh64[63:32]};
          stk_nxt = stk_r | (|sh64[31:0]);
          ex_nxt  = 11'sd1;
          st_nxt  = F_ROUND;
        end else begin
          st_nxt = F_ROUND;
        end
      end
      F_ROUND: begin
        if (fld >= 11'sd255) res_nxt = F32_INF;
        else                 res_nxt = {1'b0, fld[7:0], m25[22:0]};
        done_nxt = 1'b1;
        st_nxt   = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    w_r   <= w_nxt;
    ex_r  <= ex_nxt;
    stk_r <= stk_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign sts.idle = (st_r == F_IDLE);
  assign sts.done = done_r;
  assign res      = res_r;

endmodule

`default_nettype wire

[rtl/decimal_text_to_float32.sv]
// Top level: byte parser and sequencer around the shared float32 unit.
// Depends on dtf_pkg, dtf_chan_if and dtf_fpu.
//
// Takes one text byte per request and returns the float32 bit pattern when a
// zero byte arrives. Signs, '.', 'e' and stray bytes are handled without the
// shared float unit. An integer digit runs a multiply and an add on that unit; a
// zero product is normalized one exponent step at a time. A fraction digit adds
// a division of the place weight. The zero byte runs one multiply or one
// division per exponent unit; its last step, T_EMIT, loads the result register
// and waits while the previous result is not taken. The next byte is accepted
// while a result still waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_float32 (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dtf_char_if.sink    in_chan,
  dtf_bits_if.source  out_chan
);
  import dtf_pkg::*;

  localparam int EXPF_W = EXP_W + 4;

  seq_state_t        state_r, state_nxt;
  section_t          sec_r, sec_nxt;
  logic              neg_r, neg_nxt;
  logic              nexp_r, nexp_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       place_r, place_nxt;
  logic [EXP_W-1:0]  ecnt_r, ecnt_nxt;
  logic [3:0]        digit_r, digit_nxt;
  logic [31:0]       tmp_r, tmp_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_bits_r, out_bits_nxt;

  fpu_req_t          freq;
  fpu_sts_t          fsts;
  logic [31:0]       fpu_a, fpu_b, fpu_res;

  logic [7:0]        c;
  logic              in_acc, is_dig, is_e, op_state;
  logic [3:0]        d4;
  logic [EXPF_W-1:0] e_full;
  section_t          int_sec;
  logic              int_go;

  dtf_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (freq),
    .a     (fpu_a),
    .b     (fpu_b),
    .sts   (fsts),
    .res   (fpu_res)
  );

  assign in_chan.ready       = (state_r == T_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.value_bits = out_bits_r;

  always_comb begin
    c      = in_chan.char_code;
    in_acc = in_chan.valid && (state_r == T_IDLE);
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    is_e   = (c == CH_E_LO) || (c == CH_E_UP);
    d4     = 4'(c - CH_ZERO);
    e_full = EXPF_W'(ecnt_r) * EXPF_W'(10) + EXPF_W'(d4);
    int_go = 1'b0;
    priority if (c == CH_DOT) int_sec = SEC_FRAC;
    else if (is_e)            int_sec = SEC_EXPSIGN;
    else if (is_dig) begin
      int_sec = SEC_INT;
      int_go  = 1'b1;
    end else                  int_sec = SEC_DONE;

    op_state = (state_r == T_INT_MUL) || (state_r == T_INT_ADD) ||
               (state_r == T_FRAC_MUL) || (state_r == T_FRAC_ADD) ||
               (state_r == T_FRAC_DIV) || (state_r == T_EXP);

    freq.start = op_state && !pend_r;
    freq.op    = OP_MUL;
    freq.k     = K_TEN;
    fpu_a      = acc_r;
    fpu_b      = F32_ZERO;

    state_nxt     = state_r;
    sec_nxt       = sec_r;
    neg_nxt       = neg_r;
    nexp_nxt      = nexp_r;
    acc_nxt       = acc_r;
    place_nxt     = place_r;
    ecnt_nxt      = ecnt_r;
    digit_nxt     = digit_r;
    tmp_nxt       = tmp_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_bits_nxt  = out_bits_r;

    if (freq.start) pend_nxt = 1'b1;

    unique case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          digit_nxt = d4;
          if (c == CH_NUL) begin
            state_nxt = (ecnt_r == '0) ? T_EMIT : T_EXP;
          end else begin
            unique case (sec_r)
              SEC_LEAD: begin
                priority if (c == CH_MINUS) begin
                  neg_nxt = 1'b1;
                  sec_nxt = SEC_INT;
                end else if (c == CH_PLUS) begin
                  neg_nxt = 1'b0;
                  sec_nxt = SEC_INT;
                end else begin
                  sec_nxt = int_sec;
                  if (int_go) state_nxt = T_INT_MUL;
                end
              end
              SEC_INT: begin
                sec_nxt = int_sec;
                if (int_go) state_nxt = T_INT_MUL;
              end
              SEC_FRAC: begin
                priority if (is_e) sec_nxt = SEC_EXPSIGN;
                else if (is_dig)   state_nxt = T_FRAC_MUL;
                else               sec_nxt = SEC_DONE;
              end
              SEC_EXPSIGN: begin
                priority if (c == CH_PLUS) begin
                  nexp_nxt = 1'b0;
                  sec_nxt  = SEC_EXPDIG;
                end else if (c == CH_MINUS) begin
                  nexp_nxt = 1'b1;
                  sec_nxt  = SEC_EXPDIG;
                end else begin
                  sec_nxt = SEC_DONE;
                end
              end
              SEC_EXPDIG: begin
                if (is_dig) begin
                  if (e_full > EXPF_W'(EXPONENT_CAP)) ecnt_nxt = EXP_W'(EXPONENT_CAP);
                  else                                ecnt_nxt = e_full[EXP_W-1:0];
                end else begin
                  sec_nxt = SEC_DONE;
                end
              end
              default: sec_nxt = SEC_DONE;
            endcase
          end
        end
      end
      T_INT_MUL: begin
        if (fsts.done) begin
          tmp_nxt   = fpu_res;
          pend_nxt  = 1'b0;
          state_nxt = T_INT_ADD;
        end
      end
      T_INT_ADD: begin
        freq.op = OP_ADD;
        fpu_a   = tmp_r;
        fpu_b   = digit_f32(digit_r);
        if (fsts.done) begin
          acc_nxt   = fpu_res;
          pend_nxt  = 1'b0;
          state_nxt = T_IDLE;
        end
      end
      T_FRAC_MUL: begin
        freq.k = digit_r;
        fpu_a  = place_r;
        if (fsts.done) begin
          tmp_nxt   = fpu_res;
          pend_nxt  = 1'b0;
          state_nxt = T_FRAC_ADD;
        end
      end
      T_FRAC_ADD: begin
        freq.op = OP_ADD;
        fpu_b   = tmp_r;
        if (fsts.done) begin
          acc_nxt   = fpu_res;
          pend_nxt  = 1'b0;
          state_nxt = T_FRAC_DIV;
        end
      end
      T_FRAC_DIV: begin
        freq.op = OP_DIV;
        fpu_a   = place_r;
        if (fsts.done) begin
          place_nxt = fpu_res;
          pend_nxt  = 1'b0;
          state_nxt = T_IDLE;
        end
      end
      T_EXP: begin
        freq.op = nexp_r ? OP_DIV : OP_MUL;
        if (fsts.done) begin
          acc_nxt  = fpu_res;
          pend_nxt = 1'b0;
          ecnt_nxt = ecnt_r - EXP_W'(1);
          if (ecnt_r == EXP_W'(1)) state_nxt = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = acc_r ^ {neg_r, 31'd0};
          sec_nxt       = SEC_LEAD;
          neg_nxt       = 1'b0;
          nexp_nxt      = 1'b0;
          acc_nxt       = F32_ZERO;
          place_nxt     = F32_TENTH;
          ecnt_nxt      = '0;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      sec_r       <= SEC_LEAD;
      neg_r       <= 1'b0;
      nexp_r      <= 1'b0;
      acc_r       <= F32_ZERO;
      place_r     <= F32_TENTH;
      ecnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      neg_r       <= neg_nxt;
      nexp_r      <= nexp_nxt;
      acc_r       <= acc_nxt;
      place_r     <= place_nxt;
      ecnt_r      <= ecnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    digit_r    <= digit_nxt;
    tmp_r      <= tmp_nxt;
    out_bits_r <= out_bits_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    freq.start |-> fsts.idle) else $error("float unit started while busy");

  a_done_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fsts.done |-> pend_r) else $error("float unit result without a request");

  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_EMIT && !out_valid_r) |=> out_valid_r)
    else $error("result register not loaded");

  a_nul_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && c == CH_NUL && ecnt_r == '0) |=> (state_r == T_EMIT))
    else $error("terminator without exponent did not go to emit");

  a_ecnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= EXP_W'(EXPONENT_CAP)) else $error("exponent count above cap");

endmodule

`default_nettype wire

[tb/dtf_checker.sv]
// Scoreboard for decimal_text_to_float32: watches the byte and result channels,
// predicts each float32 pattern with per-operation rounding, and counts mismatches.
// Depends on dtf_pkg and the channel interfaces in dtf_chan_if.
`timescale 1ns / 1ps

module dtf_checker (
  input  logic clk,
  input  logic rst_n,
  dtf_char_if  in_chan,
  dtf_bits_if  out_chan,
  output int   fail_count,
  output int   pending_count,
  output int   bytes_seen,
  output int   numbers_checked
);
  import dtf_pkg::*;

  section_t      sect;
  logic          neg_val;
  logic          neg_exp;
  logic [31:0]   acc_bits;
  logic [31:0]   place_bits;
  int            exp_count;
  logic [31:0]   expected_bits[$];

  function automatic real f32_value(input logic [31:0] b);
    logic [10:0] e;
    if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, 52'b0});
    if (b[30:23] == 8'h00)
      return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** (-149));
    e = 11'(b[30:23]) + 11'd896;
    return $bitstoreal({b[31], e, b[22:0], 29'b0});
  endfunction

  // round a double to the nearest float32, ties to even
  function automatic logic [31:0] round_f32(input real r);
    logic [63:0] d;
    logic [63:0] mant;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic        s;
    int          e;
    int          sh;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'd0) return {s, 31'b0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {s, 8'hFF, 23'b0};
    mant = {11'b0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) sh = 60;
    kept = mant >> sh;
    rem  = mant & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (e >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        e++;
      end
      if (e > 127) return {s, 8'hFF, 23'b0};
      return {s, 8'(e + 127), kept[22:0]};
    end
    return {s, kept[30:0]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [31:0] final_value();
    logic [31:0] v;
    v = acc_bits;
    for (int n = 0; n < exp_count; n++)
      v = neg_exp ? round_f32(f32_value(v) / 10.0) : round_f32(f32_value(v) * 10.0);
    return neg_val ? (v ^ 32'h8000_0000) : v;
  endfunction

  task automatic clear_number();
    sect       = SEC_LEAD;
    neg_val    = 1'b0;
    neg_exp    = 1'b0;
    acc_bits   = F32_ZERO;
    place_bits = F32_TENTH;
    exp_count  = 0;
  endtask

  task automatic int_char(input logic [7:0] c);
    logic [31:0] scaled;
    if (c == CH_DOT) begin
      sect = SEC_FRAC;
    end else if (c == CH_E_LO || c == CH_E_UP) begin
      sect = SEC_EXPSIGN;
    end else if (is_digit(c)) begin
      scaled   = round_f32(f32_value(acc_bits) * 10.0);
      acc_bits = round_f32(f32_value(scaled) + real'(c - CH_ZERO));
    end else begin
      sect = SEC_DONE;
    end
  endtask

  task automatic absorb_char(input logic [7:0] c);
    logic [31:0] part;
    if (c == CH_NUL) begin
      expected_bits.push_back(final_value());
      clear_number();
      return;
    end
    case (sect)
      SEC_LEAD: begin
        sect = SEC_INT;
        if (c == CH_MINUS) neg_val = 1'b1;
        else if (c == CH_PLUS) neg_val = 1'b0;
        else int_char(c);
      end
      SEC_INT: int_char(c);
      SEC_FRAC: begin
        if (c == CH_E_LO || c == CH_E_UP) begin
          sect = SEC_EXPSIGN;
        end else if (is_digit(c)) begin
          part       = round_f32(f32_value(place_bits) * real'(c - CH_ZERO));
          acc_bits   = round_f32(f32_value(acc_bits) + f32_value(part));
          place_bits = round_f32(f32_value(place_bits) / 10.0);
        end else begin
          sect = SEC_DONE;
        end
      end
      SEC_EXPSIGN: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg_exp = (c == CH_MINUS);
          sect    = SEC_EXPDIG;
        end else begin
          sect = SEC_DONE;
        end
      end
      SEC_EXPDIG: begin
        if (is_digit(c)) begin
          exp_count = exp_count * 10 + int'(c - CH_ZERO);
          if (exp_count > EXPONENT_CAP) exp_count = EXPONENT_CAP;
        end else begin
          sect = SEC_DONE;
        end
      end
      default: sect = SEC_DONE;
    endcase
  endtask

  initial begin
    fail_count      = 0;
    bytes_seen      = 0;
    numbers_checked = 0;
    clear_number();
  end

  assign pending_count = expected_bits.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_number();
      expected_bits.delete();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        bytes_seen++;
        absorb_char(in_chan.char_code);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_bits.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %h", $time,
                   out_chan.value_bits);
        end else begin
          numbers_checked++;
          if (out_chan.value_bits !== expected_bits[0]) begin
            fail_count++;
            $display("%0t: value_bits mismatch, expected %h, got %h", $time,
                     expected_bits[0], out_chan.value_bits);
          end
          void'(expected_bits.pop_front());
        end
      end
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for decimal_text_to_float32: drives number strings byte by byte
// under several idle and stall mixes and gives the verdict from dtf_checker.
// Depends on dtf_pkg, dtf_chan_if, dtf_checker and the block itself.
`timescale 1ns / 1ps

module tb;
  import dtf_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_BYTES = 340;

  logic clk;
  logic rst_n;
  int   cycles;
  int   idle_pct;
  int   stall_pct;
  int   fail_count;
  int   pending_count;
  int   bytes_seen;
  int   numbers_checked;
  int   sent;

  dtf_char_if in_chan ();
  dtf_bits_if out_chan ();

  decimal_text_to_float32 i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  dtf_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .bytes_seen      (bytes_seen),
    .numbers_checked (numbers_checked)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic put_char(input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= c;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    put_char(CH_NUL);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // mostly well-formed numbers with small exponents, some noise
  task automatic put_random_number();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(5);
      for (int i = 0; i < n; i++) put_char(8'($urandom_range(255, 1)));
      put_char(CH_NUL);
      return;
    end
    case ($urandom_range(3))
      0: put_char(CH_MINUS);
      1: put_char(CH_PLUS);
      default: ;
    endcase
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) put_char(rand_digit());
    if ($urandom_range(1)) begin
      put_char(CH_DOT);
      n = $urandom_range(4);
      for (int i = 0; i < n; i++) put_char(rand_digit());
    end
    if (kind < 20) put_char(8'($urandom_range(255, 1)));
    if ($urandom_range(2) == 0) begin
      put_char($urandom_range(1) ? CH_E_LO : CH_E_UP);
      if (kind < 24) put_char(rand_digit());
      else put_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
      put_char(rand_digit());
      if ($urandom_range(3) == 0) put_char(rand_digit());
      if ($urandom_range(40) == 0) put_char(rand_digit());
    end
    put_char(CH_NUL);
  endtask

  task automatic run_phase(input int idle, input int stall);
    int target;
    idle_pct  = idle;
    stall_pct = stall;
    target    = sent + PHASE_BYTES;
    while (sent < target) put_random_number();
  endtask

  initial begin
    cycles            = 0;
    sent              = 0;
    idle_pct          = 0;
    stall_pct         = 0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.char_code = CH_NUL;
    out_chan.ready    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_text("");
    put_text("-0");
    put_text("+5");
    put_text("123");
    put_text("-3.14159");
    put_text(".5");
    put_text("1.5e+3");
    put_text("2E-2");
    put_text("1e5");
    put_text("9e+99");
    put_text("1e+999");
    put_text("1e-999");
    put_text("12x34");
    put_text("1.2.3");
    put_text("-.e+2");
    put_char(8'hFF);
    put_char(CH_NUL);

    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(35, 35);
    run_phase(0, 0);

    in_chan.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d text bytes, checked %0d float32 results", bytes_seen,
             numbers_checked);
    $display("Covered signs, fractions, exponents, saturation and stray bytes");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
